>>> hw/rtl/bba_pkg.sv
// Shared types, constants and helpers for the block bitmap allocator.
// No dependencies; the other files that use it refer to it by scoped names.
package bba_pkg;

    localparam int unsigned DEF_BLOCK_TOTAL = 1024;
    localparam int unsigned DEF_BLOCK_BYTES = 1024;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned WBIT_W    = 5;
    localparam int unsigned TRUN_W    = 6;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned SIZE_W   = 21;
    localparam int unsigned RSTART_W = 10;
    localparam int unsigned RLEN_W   = 11;
    localparam int unsigned START_W  = 10;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned DIVD_W   = 22;
    localparam int unsigned POS_W    = 18;

    localparam logic [OP_W-1:0] OP_FIND_RUN   = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK       = 2'd1;
    localparam logic [OP_W-1:0] OP_FIRST_FREE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SRCH,
        ST_MARK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              hit;
        logic [WBIT_W-1:0] hit_pos;
        logic              all_free;
        logic [TRUN_W-1:0] top_run;
    } scan_res_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] wdata;
        logic [TRUN_W-1:0]    flips;
    } mark_res_t;

    function automatic logic [COUNT_W-1:0] sat_cnt(input logic [31:0] v);
        logic [31:0] lim;
        lim = 32'((1 << COUNT_W) - 1);
        sat_cnt = (v > lim) ? lim[COUNT_W-1:0] : v[COUNT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/bba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bba_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/bba_div.sv
// Block count divider: ceil(size / BLOCK_BYTES) by reciprocal multiply and one
// correction step, staged in ph1, ph2 and done. Depends on bba_pkg.
module bba_div #(
    parameter int unsigned BLOCK_BYTES = bba_pkg::DEF_BLOCK_BYTES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start_i,
    input  logic [bba_pkg::SIZE_W-1:0]  size_i,
    output logic                        done_o,
    output logic [bba_pkg::DIVD_W-1:0]  quot_o
);

    localparam int unsigned DW      = bba_pkg::DIVD_W;
    localparam int unsigned RECIP_V = (1 << DW) / BLOCK_BYTES;
    localparam int unsigned RW      = $clog2(RECIP_V + 1);
    localparam logic [RW-1:0] RECIP   = RW'(RECIP_V);
    localparam logic [DW-1:0] DIVISOR = DW'(BLOCK_BYTES);
    localparam logic [DW-1:0] BIAS    = DW'(BLOCK_BYTES - 1);

    logic             ph1_reg, ph1_next;
    logic             ph2_reg, ph2_next;
    logic             done_reg, done_next;
    logic [DW-1:0]    num_reg, num_next;
    logic [DW-1:0]    quot_reg, quot_next;
    logic [DW+RW-1:0] prod;
    logic [DW-1:0]    back;
    logic [DW-1:0]    rem;

    // estimate is exact or one low; the second phase fixes it
    always_comb begin
        prod      = {RW'(0), num_reg} * {DW'(0), RECIP};
        back      = quot_reg * DIVISOR;
        rem       = num_reg - back;
        ph1_next  = start_i;
        ph2_next  = ph1_reg;
        done_next = ph2_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        if (start_i) begin
            num_next = DW'(size_i) + BIAS;
        end
        if (ph1_reg) begin
            quot_next = DW'(prod[DW+RW-1:DW]);
        end else if (ph2_reg) begin
            quot_next = (rem >= DIVISOR) ? quot_reg + 1'b1 : quot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph1_reg  <= 1'b0;
            ph2_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            ph1_reg  <= ph1_next;
            ph2_reg  <= ph2_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
    end

    assign done_o = done_reg;
    assign quot_o = quot_reg;

endmodule

>>> hw/rtl/bba_word.sv
// Shared word unit: run search step and run mark step over one 32-bit bitmap word.
// Depends on bba_pkg.
module bba_word #(
    parameter int unsigned CNT_W = 11
) (
    input  logic [bba_pkg::WORD_BITS-1:0] used_i,
    input  logic [CNT_W-1:0]              len_i,
    input  logic [CNT_W-1:0]              need_i,
    output bba_pkg::scan_res_t            scan_o,
    input  logic [bba_pkg::WORD_BITS-1:0] old_i,
    input  logic [bba_pkg::WBIT_W-1:0]    lo_i,
    input  logic [bba_pkg::WBIT_W-1:0]    hi_i,
    input  logic                          full_i,
    output bba_pkg::mark_res_t            mark_o
);

    localparam int unsigned WB    = bba_pkg::WORD_BITS;
    localparam int unsigned RUN_W = ((CNT_W > bba_pkg::TRUN_W) ? CNT_W : bba_pkg::TRUN_W) + 1;

    logic                       seen_a [WB];
    logic [bba_pkg::WBIT_W-1:0] lu_a   [WB];
    logic [RUN_W-1:0]           run_a  [WB];
    logic [WB-1:0]              match;
    logic [WB-1:0]              mask;
    logic [WB-1:0]              new_w;
    logic [WB-1:0]              diff;
    logic [bba_pkg::TRUN_W-1:0] pop;

    // run of free blocks ending at each bit, carrying the run from earlier words
    always_comb begin
        for (int j = 0; j < WB; j++) begin
            seen_a[j] = 1'b0;
            lu_a[j]   = '0;
            for (int k = 0; k < WB; k++) begin
                if (k <= j && used_i[k]) begin
                    seen_a[j] = 1'b1;
                    lu_a[j]   = bba_pkg::WBIT_W'(k);
                end
            end
            run_a[j] = seen_a[j] ? RUN_W'(j) - RUN_W'(lu_a[j])
                                 : RUN_W'(len_i) + RUN_W'(j + 1);
            match[j] = run_a[j] >= RUN_W'(need_i);
        end
        scan_o.hit     = |match;
        scan_o.hit_pos = '0;
        for (int j = WB - 1; j >= 0; j--) begin
            if (match[j]) begin
                scan_o.hit_pos = bba_pkg::WBIT_W'(j);
            end
        end
        scan_o.all_free = !seen_a[WB-1];
        scan_o.top_run  = seen_a[WB-1] ?
            bba_pkg::TRUN_W'(WB - 1) - bba_pkg::TRUN_W'(lu_a[WB-1]) : bba_pkg::TRUN_W'(WB);
    end

    always_comb begin
        for (int j = 0; j < WB; j++) begin
            mask[j] = (bba_pkg::WBIT_W'(j) >= lo_i) && (bba_pkg::WBIT_W'(j) <= hi_i);
        end
        new_w = full_i ? (old_i | mask) : (old_i & ~mask);
        diff  = old_i ^ new_w;
        pop   = '0;
        for (int j = 0; j < WB; j++) begin
            pop = pop + bba_pkg::TRUN_W'(diff[j]);
        end
        mark_o.wdata = new_w;
        mark_o.flips = pop;
    end

endmodule

>>> hw/rtl/block_bitmap_allocator.sv
// Block bitmap allocator top level: sequencer, free counter and result register.
// Depends on bba_pkg, bba_ram, bba_div and bba_word.
//
// One used/free bit per block, kept in a RAM of 32-bit words. Input words carry
// op, size_bytes, run_start, run_length and mark_full on s_valid/s_ready; each
// gives exactly one result word (found, first_block, block_count, free_count) on
// m_valid/m_ready. s_ready is high only while the sequencer is idle.
// Op 0: reciprocal division for the block count, then, unless the count exceeds
// BLOCK_TOTAL, a first-fit scan of one bitmap word per cycle, stopping at the
// first fit. Op 1 reads and writes back one word per cycle over the marked range.
// Op 2 scans like op 0 without the division. Other ops go straight to the result.
// s_ready rises as the result is registered. The word unit and the single RAM
// port pair set the one-word-per-cycle pace.
// After reset a clearing pass writes every RAM word free before the first input
// is taken.
// The result sits in an output register; if the receiver stalls, a finished
// op waits until the register empties, and no new input is taken meanwhile.
module block_bitmap_allocator #(
    parameter int unsigned BLOCK_TOTAL = bba_pkg::DEF_BLOCK_TOTAL,
    parameter int unsigned BLOCK_BYTES = bba_pkg::DEF_BLOCK_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bba_pkg::OP_W-1:0]      s_op,
    input  logic [bba_pkg::SIZE_W-1:0]    s_size_bytes,
    input  logic [bba_pkg::RSTART_W-1:0]  s_run_start,
    input  logic [bba_pkg::RLEN_W-1:0]    s_run_length,
    input  logic                          s_mark_full,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [bba_pkg::START_W-1:0]   m_first_block,
    output logic [bba_pkg::COUNT_W-1:0]   m_block_count,
    output logic [bba_pkg::COUNT_W-1:0]   m_free_count
);

    localparam int unsigned WB        = bba_pkg::WORD_BITS;
    localparam int unsigned WBIT_W    = bba_pkg::WBIT_W;
    localparam int unsigned POS_W     = bba_pkg::POS_W;
    localparam int unsigned CNT_W     = $clog2(BLOCK_TOTAL + 1);
    localparam int unsigned NUM_WORDS = (BLOCK_TOTAL + WB - 1) / WB;
    localparam int unsigned WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned LAST_WORD = NUM_WORDS - 1;
    localparam int unsigned TAIL_BITS = BLOCK_TOTAL - LAST_WORD * WB;

    bba_pkg::state_t state_reg, state_next;

    logic                          full_reg, full_next;
    logic [CNT_W-1:0]              need_reg, need_next;
    logic [CNT_W-1:0]              len_reg, len_next;
    logic [CNT_W-1:0]              free_reg, free_next;
    logic [WA_W-1:0]               waddr_reg, waddr_next;
    logic [WA_W-1:0]               eword_reg, eword_next;
    logic [WA_W-1:0]               sword_reg, sword_next;
    logic [WBIT_W-1:0]             sbit_reg, sbit_next;
    logic [WBIT_W-1:0]             ebit_reg, ebit_next;
    logic                          res_found_reg, res_found_next;
    logic [bba_pkg::START_W-1:0]   res_start_reg, res_start_next;
    logic [bba_pkg::COUNT_W-1:0]   res_count_reg, res_count_next;

    logic                          m_valid_reg;
    logic                          m_found_reg;
    logic [bba_pkg::START_W-1:0]   m_start_reg;
    logic [bba_pkg::COUNT_W-1:0]   m_count_reg;
    logic [bba_pkg::COUNT_W-1:0]   m_free_reg;
    logic                          load_out;

    logic                          ram_we;
    logic [WA_W-1:0]               ram_waddr;
    logic [WB-1:0]                 ram_wdata;
    logic [WA_W-1:0]               ram_raddr;
    logic [WB-1:0]                 ram_rdata;

    logic                          div_start;
    logic                          div_done;
    logic [bba_pkg::DIVD_W-1:0]    div_quot;

    logic [WB-1:0]                 vmask;
    logic [WB-1:0]                 used_eff;
    logic [WBIT_W-1:0]             mark_lo;
    logic [WBIT_W-1:0]             mark_hi;
    bba_pkg::scan_res_t            scan;
    bba_pkg::mark_res_t            mark;

    logic [POS_W-1:0]              rs_ext;
    logic [POS_W-1:0]              end_raw;
    logic [POS_W-1:0]              end_clip;
    logic [POS_W-1:0]              end_last;
    logic [POS_W-1:0]              hit_start;
    logic [CNT_W-1:0]              run_n;

    bba_ram #(
        .WIDTH (WB),
        .DEPTH (NUM_WORDS),
        .AW    (WA_W)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_div #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .size_i  (s_size_bytes),
        .done_o  (div_done),
        .quot_o  (div_quot)
    );

    bba_word #(
        .CNT_W (CNT_W)
    ) u_word (
        .used_i (used_eff),
        .len_i  (len_reg),
        .need_i (need_reg),
        .scan_o (scan),
        .old_i  (ram_rdata),
        .lo_i   (mark_lo),
        .hi_i   (mark_hi),
        .full_i (full_reg),
        .mark_o (mark)
    );

    // bits past the last block read as used
    always_comb begin
        for (int j = 0; j < WB; j++) begin
            vmask[j] = (waddr_reg != WA_W'(LAST_WORD)) || (j < TAIL_BITS);
        end
        used_eff = ram_rdata | ~vmask;
        mark_lo  = (waddr_reg == sword_reg) ? sbit_reg : '0;
        mark_hi  = (waddr_reg == eword_reg) ? ebit_reg : WBIT_W'(WB - 1);
    end

    always_comb begin
        rs_ext    = POS_W'(s_run_start);
        end_raw   = rs_ext + POS_W'(s_run_length);
        end_clip  = (end_raw > POS_W'(BLOCK_TOTAL)) ? POS_W'(BLOCK_TOTAL) : end_raw;
        end_last  = end_clip - 1'b1;
        run_n     = CNT_W'(end_clip - rs_ext);
        hit_start = POS_W'({waddr_reg, scan.hit_pos}) + POS_W'(1) - POS_W'(need_reg);
    end

    assign s_ready = (state_reg == bba_pkg::ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        full_next      = full_reg;
        need_next      = need_reg;
        len_next       = len_reg;
        free_next      = free_reg;
        waddr_next     = waddr_reg;
        eword_next     = eword_reg;
        sword_next     = sword_reg;
        sbit_next      = sbit_reg;
        ebit_next      = ebit_reg;
        res_found_next = res_found_reg;
        res_start_next = res_start_reg;
        res_count_next = res_count_reg;
        ram_we         = 1'b0;
        ram_waddr      = waddr_reg;
        ram_wdata      = '0;
        ram_raddr      = waddr_reg;
        div_start      = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            bba_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                if (waddr_reg == WA_W'(LAST_WORD)) begin
                    waddr_next = '0;
                    state_next = bba_pkg::ST_IDLE;
                end else begin
                    waddr_next = waddr_reg + 1'b1;
                end
            end
            bba_pkg::ST_IDLE: begin
                if (s_valid) begin
                    full_next = s_mark_full;
                    unique case (s_op)
                        bba_pkg::OP_FIND_RUN: begin
                            div_start  = 1'b1;
                            state_next = bba_pkg::ST_DIV;
                        end
                        bba_pkg::OP_MARK: begin
                            res_start_next = s_run_start;
                            if (rs_ext < POS_W'(BLOCK_TOTAL) && s_run_length != '0) begin
                                res_found_next = 1'b1;
                                res_count_next = bba_pkg::sat_cnt(32'(run_n));
                                sword_next     = rs_ext[WA_W+WBIT_W-1:WBIT_W];
                                sbit_next      = rs_ext[WBIT_W-1:0];
                                eword_next     = end_last[WA_W+WBIT_W-1:WBIT_W];
                                ebit_next      = end_last[WBIT_W-1:0];
                                waddr_next     = rs_ext[WA_W+WBIT_W-1:WBIT_W];
                                ram_raddr      = rs_ext[WA_W+WBIT_W-1:WBIT_W];
                                state_next     = bba_pkg::ST_MARK;
                            end else begin
                                res_found_next = 1'b0;
                                res_count_next = '0;
                                state_next     = bba_pkg::ST_DONE;
                            end
                        end
                        bba_pkg::OP_FIRST_FREE: begin
                            res_count_next = '0;
                            need_next      = CNT_W'(1);
                            len_next       = '0;
                            waddr_next     = '0;
                            ram_raddr      = '0;
                            state_next     = bba_pkg::ST_SRCH;
                        end
                        default: begin
                            res_found_next = 1'b0;
                            res_start_next = '0;
                            res_count_next = '0;
                            state_next     = bba_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            bba_pkg::ST_DIV: begin
                if (div_done) begin
                    res_count_next = bba_pkg::sat_cnt(32'(div_quot));
                    if (32'(div_quot) > 32'(BLOCK_TOTAL)) begin
                        res_found_next = 1'b0;
                        res_start_next = '0;
                        state_next     = bba_pkg::ST_DONE;
                    end else begin
                        need_next  = (div_quot == '0) ? CNT_W'(1) : CNT_W'(div_quot);
                        len_next   = '0;
                        waddr_next = '0;
                        ram_raddr  = '0;
                        state_next = bba_pkg::ST_SRCH;
                    end
                end
            end
            bba_pkg::ST_SRCH: begin
                ram_raddr = waddr_reg + 1'b1;
                if (scan.hit) begin
                    res_found_next = 1'b1;
                    res_start_next = hit_start[bba_pkg::START_W-1:0];
                    state_next     = bba_pkg::ST_DONE;
                end else if (waddr_reg == WA_W'(LAST_WORD)) begin
                    res_found_next = 1'b0;
                    res_start_next = '0;
                    state_next     = bba_pkg::ST_DONE;
                end else begin
                    waddr_next = waddr_reg + 1'b1;
                    len_next   = scan.all_free ? CNT_W'(POS_W'(len_reg) + POS_W'(WB))
                                               : CNT_W'(scan.top_run);
                end
            end
            bba_pkg::ST_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = mark.wdata;
                ram_raddr = waddr_reg + 1'b1;
                free_next = full_reg ? free_reg - CNT_W'(mark.flips)
                                     : free_reg + CNT_W'(mark.flips);
                if (waddr_reg == eword_reg) begin
                    state_next = bba_pkg::ST_DONE;
                end else begin
                    waddr_next = waddr_reg + 1'b1;
                end
            end
            bba_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bba_pkg::ST_CLEAR;
            waddr_reg   <= '0;
            free_reg    <= CNT_W'(BLOCK_TOTAL);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            waddr_reg  <= waddr_next;
            free_reg   <= free_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        full_reg      <= full_next;
        need_reg      <= need_next;
        len_reg       <= len_next;
        eword_reg     <= eword_next;
        sword_reg     <= sword_next;
        sbit_reg      <= sbit_next;
        ebit_reg      <= ebit_next;
        res_found_reg <= res_found_next;
        res_start_reg <= res_start_next;
        res_count_reg <= res_count_next;
        if (load_out) begin
            m_found_reg <= res_found_reg;
            m_start_reg <= res_start_reg;
            m_count_reg <= res_count_reg;
            m_free_reg  <= bba_pkg::sat_cnt(32'(free_reg));
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_first_block = m_start_reg;
    assign m_block_count = m_count_reg;
    assign m_free_count  = m_free_reg;

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(free_reg) <= 32'(BLOCK_TOTAL))
        else $error("free count above block total");

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == bba_pkg::ST_DONE))
        else $error("result word raised outside done state");

    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == bba_pkg::ST_DIV)
        else $error("divider finished outside division state");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bba_pkg::ST_SRCH || state_reg == bba_pkg::ST_MARK)
            |-> 32'(waddr_reg) <= 32'(LAST_WORD))
        else $error("word address past bitmap end");

endmodule

>>> dv/block_bitmap_allocator_tb.sv
// Self-checking testbench for block_bitmap_allocator: directed and random words,
// results predicted by an in-bench copy of the used/free bitmap and free count.
// Depends on bba_pkg and the block_bitmap_allocator RTL.
module block_bitmap_allocator_tb;

    localparam int unsigned NBLK        = bba_pkg::DEF_BLOCK_TOTAL;
    localparam int unsigned BBYTES      = bba_pkg::DEF_BLOCK_BYTES;
    localparam int unsigned MAX_WAIT    = 11;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic                        found;
        logic [bba_pkg::START_W-1:0] first_block;
        logic [bba_pkg::COUNT_W-1:0] block_count;
        logic [bba_pkg::COUNT_W-1:0] free_count;
    } alloc_result_t;

    logic                         aclk         = 1'b0;
    logic                         aresetn      = 1'b0;
    logic                         s_valid      = 1'b0;
    logic                         s_ready;
    logic [bba_pkg::OP_W-1:0]     s_op         = bba_pkg::OP_FIND_RUN;
    logic [bba_pkg::SIZE_W-1:0]   s_size_bytes = '0;
    logic [bba_pkg::RSTART_W-1:0] s_run_start  = '0;
    logic [bba_pkg::RLEN_W-1:0]   s_run_length = '0;
    logic                         s_mark_full  = 1'b0;
    logic                         m_valid;
    logic                         m_ready      = 1'b0;
    logic                         m_found;
    logic [bba_pkg::START_W-1:0]  m_first_block;
    logic [bba_pkg::COUNT_W-1:0]  m_block_count;
    logic [bba_pkg::COUNT_W-1:0]  m_free_count;

    bit [NBLK-1:0]   blk_used;
    int unsigned     blk_free;
    alloc_result_t   pending_results[$];
    alloc_result_t   last_result;
    bit              steady_flow = 1'b0;
    int unsigned     ready_hold  = 0;
    int unsigned     errors      = 0;

    block_bitmap_allocator uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_size_bytes  (s_size_bytes),
        .s_run_start   (s_run_start),
        .s_run_length  (s_run_length),
        .s_mark_full   (s_mark_full),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_first_block (m_first_block),
        .m_block_count (m_block_count),
        .m_free_count  (m_free_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned lowest_free_block();
        int unsigned i;
        for (i = 0; i < NBLK; i++) begin
            if (!blk_used[i]) return i;
        end
        return NBLK;
    endfunction

    function automatic alloc_result_t apply_alloc_op(
            input logic [bba_pkg::OP_W-1:0] op,
            input logic [bba_pkg::SIZE_W-1:0] size,
            input logic [bba_pkg::RSTART_W-1:0] rstart,
            input logic [bba_pkg::RLEN_W-1:0] rlen,
            input logic full);
        alloc_result_t r;
        int unsigned   need, pos, run, stop, i;
        r = '0;
        case (op)
            bba_pkg::OP_FIND_RUN: begin
                need = (32'(size) + BBYTES - 1) / BBYTES;
                r.block_count = bba_pkg::sat_cnt(need);
                if (need == 0) begin
                    pos = lowest_free_block();
                    if (pos < NBLK) begin
                        r.found = 1'b1;
                        r.first_block = pos[bba_pkg::START_W-1:0];
                    end
                end else begin
                    run = 0;
                    for (i = 0; i < NBLK && !r.found; i++) begin
                        run = blk_used[i] ? 0 : run + 1;
                        if (run == need) begin
                            r.found = 1'b1;
                            r.first_block = bba_pkg::START_W'(i + 1 - need);
                        end
                    end
                end
            end
            bba_pkg::OP_MARK: begin
                if (32'(rstart) < NBLK) begin
                    stop = 32'(rstart) + 32'(rlen);
                    if (stop > NBLK) stop = NBLK;
                    for (i = rstart; i < stop; i++) begin
                        if (blk_used[i] != full) begin
                            blk_used[i] = full;
                            if (full) blk_free--;
                            else blk_free++;
                        end
                    end
                    r.block_count = bba_pkg::sat_cnt(stop - rstart);
                    r.found = (stop != rstart);
                end
                r.first_block = rstart;
            end
            bba_pkg::OP_FIRST_FREE: begin
                pos = lowest_free_block();
                if (pos < NBLK) begin
                    r.found = 1'b1;
                    r.first_block = pos[bba_pkg::START_W-1:0];
                end
            end
            default: ;
        endcase
        r.free_count = bba_pkg::sat_cnt(blk_free);
        return r;
    endfunction

    task automatic send_word(input logic [bba_pkg::OP_W-1:0] op,
                             input logic [bba_pkg::SIZE_W-1:0] size,
                             input logic [bba_pkg::RSTART_W-1:0] rstart,
                             input logic [bba_pkg::RLEN_W-1:0] rlen, input logic full);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_size_bytes <= size;
        s_run_start  <= rstart;
        s_run_length <= rlen;
        s_mark_full  <= full;
        do @(posedge aclk); while (s_ready !== 1'b1);
        last_result = apply_alloc_op(op, size, rstart, rlen, full);
        pending_results.push_back(last_result);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word expected none actual %0d %0d %0d %0d",
                         $time, m_found, m_first_block, m_block_count, m_free_count);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("found", 32'(want.found), 32'(m_found));
                check_field("first_block", 32'(want.first_block), 32'(m_first_block));
                check_field("block_count", 32'(want.block_count), 32'(m_block_count));
                check_field("free_count", 32'(want.free_count), 32'(m_free_count));
            end
            ready_hold = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
        end
        m_ready <= (ready_hold == 0);
        if (ready_hold != 0) ready_hold--;
    end

    task automatic test_empty_map();
        send_word(bba_pkg::OP_FIRST_FREE, 21'd0, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_FIND_RUN, 21'd0, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_FIND_RUN, 21'd1, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_FIND_RUN, 21'd1024, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_FIND_RUN, 21'd1025, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_FIND_RUN, 21'd1048575, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_FIND_RUN, 21'd1048576, 10'd0, 11'd0, 1'b0);
    endtask

    task automatic test_mark_edges();
        send_word(bba_pkg::OP_MARK, 21'd0, 10'd0, 11'd0, 1'b1);
        // clipped to the last block, then marked again while already used
        send_word(bba_pkg::OP_MARK, 21'd0, 10'd1023, 11'd1024, 1'b1);
        send_word(bba_pkg::OP_MARK, 21'd0, 10'd1023, 11'd1024, 1'b1);
        send_word(bba_pkg::OP_FIRST_FREE, 21'd0, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_MARK, 21'd0, 10'd0, 11'd1024, 1'b1);
        send_word(bba_pkg::OP_FIRST_FREE, 21'd0, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_FIND_RUN, 21'd0, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_FIND_RUN, 21'd1, 10'd0, 11'd0, 1'b0);
    endtask

    task automatic test_end_of_map_search();
        send_word(bba_pkg::OP_MARK, 21'd0, 10'd1020, 11'd4, 1'b0);
        send_word(bba_pkg::OP_FIND_RUN, 21'd4096, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_FIND_RUN, 21'd5120, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_MARK, 21'd0, 10'd3, 11'd2, 1'b0);
        send_word(bba_pkg::OP_FIND_RUN, 21'd2048, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_FIRST_FREE, 21'd0, 10'd0, 11'd0, 1'b0);
        send_word(bba_pkg::OP_MARK, 21'd0, 10'd0, 11'd1024, 1'b0);
    endtask

    task automatic test_random_traffic(input int unsigned n_words);
        int unsigned                                  k, pick, nblk, idx;
        logic [bba_pkg::OP_W-1:0]                     op;
        logic [bba_pkg::SIZE_W-1:0]                   size;
        logic [bba_pkg::RSTART_W-1:0]                 rstart;
        logic [bba_pkg::RLEN_W-1:0]                   rlen;
        logic                                         full;
        logic [bba_pkg::RSTART_W+bba_pkg::RLEN_W-1:0] held_runs[$];
        bit                                           claim_next;
        claim_next = 1'b0;
        for (k = 0; k < n_words; k++) begin
            steady_flow = (k % 400) >= 330;
            if (k % 300 == 299) wait_results_drained();
            size   = bba_pkg::SIZE_W'($urandom_range(0, 1048576));
            rstart = bba_pkg::RSTART_W'($urandom);
            rlen   = bba_pkg::RLEN_W'($urandom_range(0, 1024));
            full   = 1'($urandom_range(0, 1));
            pick   = $urandom_range(0, 99);
            if (claim_next) begin
                // allocate the run just found
                op = bba_pkg::OP_MARK;
                rstart = last_result.first_block;
                rlen = last_result.block_count;
                full = 1'b1;
                held_runs.push_back({rstart, rlen});
                claim_next = 1'b0;
            end else if (pick < 40) begin
                op = bba_pkg::OP_FIND_RUN;
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    size = '0;
                end else if (pick < 85) begin
                    nblk = $urandom_range(1, 40);
                    size = bba_pkg::SIZE_W'((nblk - 1) * BBYTES + $urandom_range(1, BBYTES));
                end
            end else if (pick < 55 && held_runs.size() != 0) begin
                idx = $urandom_range(0, held_runs.size() - 1);
                {rstart, rlen} = held_runs[idx];
                held_runs.delete(idx);
                op = bba_pkg::OP_MARK;
                full = 1'b0;
            end else if (pick < 80) begin
                op = bba_pkg::OP_MARK;
                if ($urandom_range(0, 9) < 8) rlen = bba_pkg::RLEN_W'($urandom_range(0, 48));
                if (blk_free < 200) full = ($urandom_range(0, 3) == 0);
                else if (blk_free > 800) full = ($urandom_range(0, 3) != 0);
            end else begin
                op = bba_pkg::OP_FIRST_FREE;
            end
            send_word(op, size, rstart, rlen, full);
            if (op == bba_pkg::OP_FIND_RUN && last_result.found
                    && last_result.block_count != 0 && $urandom_range(0, 9) < 7)
                claim_next = 1'b1;
        end
    endtask

    initial begin : watchdog
        int unsigned n;
        for (n = 0; n < CYCLE_LIMIT; n++) @(posedge aclk);
        $display("FAIL block_bitmap_allocator");
        $finish;
    end

    initial begin
        blk_used = '0;
        blk_free = NBLK;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_map();
        test_mark_edges();
        test_end_of_map_search();
        test_random_traffic(1800);
        wait_results_drained();
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS block_bitmap_allocator");
        end else begin
            $display("FAIL block_bitmap_allocator");
        end
        $finish;
    end

endmodule

>>> block_bitmap_allocator.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_div.sv
hw/rtl/bba_word.sv
hw/rtl/block_bitmap_allocator.sv
dv/block_bitmap_allocator_tb.sv
